### src/srdz_pkg.sv
// Shared constants, types and the divider step function for the stick radial dead zone block.
package srdz_pkg;

   localparam int AXIS_BITS = 16;
   localparam int FRAC_BITS = 15;
   localparam int CFG_BITS  = 16;
   // Magnitude of one axis, one bit wider than a signed axis value minus the sign.
   localparam int MAG_BITS  = AXIS_BITS;
   // Sum of two squares of magnitudes.
   localparam int SQ_BITS   = 2 * MAG_BITS + 1;
   // Square root width, rounded up to whole result bits.
   localparam int LEN_BITS  = (SQ_BITS + 1) / 2;
   localparam int SQ_PAD    = 2 * LEN_BITS;
   // Dividend of the gain division: (len - dead) << FRAC_BITS.
   localparam int GNUM_BITS = LEN_BITS + FRAC_BITS;
   // Gain width and product width of one axis.
   localparam int GAIN_BITS = FRAC_BITS;
   localparam int PROD_BITS = MAG_BITS + GAIN_BITS;
   localparam int DIVR_BITS = LEN_BITS + 1;

   localparam logic [CFG_BITS-1:0] DEAD_RESET = CFG_BITS'(8000);
   localparam logic [CFG_BITS-1:0] FULL_RESET = CFG_BITS'(30000);
   localparam logic [GAIN_BITS-1:0] GAIN_MAX  = {GAIN_BITS{1'b1}};

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      CSR_DEAD_ZONE  = 1'b0,
      CSR_FULL_SCALE = 1'b1
   } csr_index_type;

   // Data handed from one square root cell to the next.
   typedef struct packed {
      logic                        valid;
      logic [SQ_PAD-1:0]           rem;
      logic [LEN_BITS-1:0]         root;
      logic signed [AXIS_BITS-1:0] ax;
      logic signed [AXIS_BITS-1:0] ay;
   } sqrt_lane_type;

   // Data handed from one divider cell to the next. A single shared cell shape
   // serves the gain divide and the two axis divides (the two axis lanes side by side).
   typedef struct packed {
      logic [PROD_BITS:0]   rem;
      logic [PROD_BITS-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                        valid;
      logic                        dead;
      logic                        zero;
      logic                        sat;
      logic [LEN_BITS-1:0]         len;
      logic [DIVR_BITS-1:0]        span;
      logic signed [AXIS_BITS-1:0] ax;
      logic signed [AXIS_BITS-1:0] ay;
      div_lane_type                g;
   } gain_lane_type;

   typedef struct packed {
      logic                 valid;
      logic                 dead;
      logic                 zero;
      logic                 neg_x;
      logic                 neg_y;
      logic [LEN_BITS-1:0]  len;
      div_lane_type         dx;
      div_lane_type         dy;
   } scale_lane_type;

   // One restoring division step: shift in the next dividend bit and try to subtract.
   function automatic div_lane_type div_step(div_lane_type d, logic nbit,
                                             logic [DIVR_BITS-1:0] divisor);
      div_lane_type         r;
      logic [PROD_BITS+1:0] t;
      r = d;
      t = {d.rem, nbit};
      if (t >= {{(PROD_BITS + 2 - DIVR_BITS){1'b0}}, divisor}) begin
         t = t - {{(PROD_BITS + 2 - DIVR_BITS){1'b0}}, divisor};
         r.quo = {d.quo[PROD_BITS-2:0], 1'b1};
      end else begin
         r.quo = {d.quo[PROD_BITS-2:0], 1'b0};
      end
      r.rem = t[PROD_BITS:0];
      return r;
   endfunction

endpackage

### src/stick_radial_dead_zone.sv
// Top level of the stick radial dead zone block: length, gain and axis scaling chains.
//
// Usage: a stick sample (req_axis_x, req_axis_y) enters on the req_ channel;
// one result (rsp_out_x, rsp_out_y, rsp_in_dead_zone) leaves on rsp_ per sample.
// Both channels use valid/ready; an item moves when both are high.
// The csr_ channel writes dead_zone (index 0) and full_scale (index 1); it is
// always ready and should be written only while no item is in flight.
// Throughput: one item per cycle unless the receiver stalls. The datapath
// is a row of cells that each settle one bit: a square root chain of
// LEN_BITS cells, the gain setup register, a gain divider chain, the scale
// setup register, an axis divider chain (each chain PROD_BITS cells) and the output register.
// The whole row advances together; when the receiver stalls with a result
// held in the output register, the row holds, and req_ready drops until it
// moves again. Results stay in order.
// Reset clears every valid flag and loads the register reset values.
module stick_radial_dead_zone
   import srdz_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [AXIS_BITS-1:0] req_axis_x,
   input  logic signed [AXIS_BITS-1:0] req_axis_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [AXIS_BITS-1:0] rsp_out_x,
   output logic signed [AXIS_BITS-1:0] rsp_out_y,
   output logic                        rsp_in_dead_zone,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [0:0]                  csr_index,
   input  logic [CFG_BITS-1:0]         csr_data
);

   logic [CFG_BITS-1:0] dead_ff, full_ff;
   logic advance;

   sqrt_lane_type  sq [0:LEN_BITS];
   gain_lane_type  gl [0:PROD_BITS];
   scale_lane_type sl [0:PROD_BITS];
   gain_lane_type  gain_ff;
   scale_lane_type scale_head;
   logic [PROD_BITS-1:0] num_x_ff [0:PROD_BITS];
   logic [PROD_BITS-1:0] num_y_ff [0:PROD_BITS];
   logic [PROD_BITS-1:0] num_x_c, num_y_c;

   logic                        rsp_valid_ff;
   logic signed [AXIS_BITS-1:0] out_x_ff, out_y_ff;
   logic                        dead_out_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         dead_ff <= DEAD_RESET;
         full_ff <= FULL_RESET;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEAD_ZONE:  dead_ff <= csr_data;
            CSR_FULL_SCALE: full_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // The row moves whenever the output register is empty or being emptied.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Square root chain head: sum of squares of the magnitudes.
   logic [MAG_BITS-1:0]   mx, my;
   logic [2*MAG_BITS-1:0] px, py;
   always_comb begin
      mx = req_axis_x[AXIS_BITS-1] ? MAG_BITS'(-req_axis_x) : MAG_BITS'(req_axis_x);
      my = req_axis_y[AXIS_BITS-1] ? MAG_BITS'(-req_axis_y) : MAG_BITS'(req_axis_y);
      px = mx * mx;
      py = my * my;
      sq[0].valid = req_valid;
      sq[0].rem   = SQ_PAD'(px) + SQ_PAD'(py);
      sq[0].root  = {LEN_BITS{1'b0}};
      sq[0].ax    = req_axis_x;
      sq[0].ay    = req_axis_y;
   end

   for (genvar i = 0; i < LEN_BITS; i++) begin : g_sqrt
      srdz_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .step     ($clog2(LEN_BITS)'(i)),
         .lane_in  (sq[i]),
         .lane_out (sq[i+1])
      );
   end

   // Gain setup: dead zone test, zero length test, saturation test and divisor.
   logic [LEN_BITS-1:0] len_w;
   assign len_w = sq[LEN_BITS].root;
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff.valid <= 1'b0;
      end else if (advance) begin
         gain_ff.valid <= sq[LEN_BITS].valid;
         gain_ff.dead  <= len_w < LEN_BITS'(dead_ff);
         gain_ff.zero  <= len_w == '0;
         gain_ff.sat   <= full_ff <= dead_ff;
         gain_ff.len   <= len_w - LEN_BITS'(dead_ff);
         gain_ff.span  <= DIVR_BITS'(full_ff) - DIVR_BITS'(dead_ff);
         gain_ff.ax    <= sq[LEN_BITS].ax;
         gain_ff.ay    <= sq[LEN_BITS].ay;
         gain_ff.g     <= '0;
      end
   end

   // The true length travels alongside the gain chain.
   logic [LEN_BITS-1:0] tlen_ff [0:PROD_BITS];
   always_ff @(posedge clock) begin
      if (advance) tlen_ff[0] <= len_w;
   end

   assign gl[0] = gain_ff;
   for (genvar i = 0; i < PROD_BITS; i++) begin : g_gain
      scale_lane_type unused_s;
      srdz_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .gain_stage (1'b1),
         .step       ($clog2(PROD_BITS)'(i)),
         .gain_in    (gl[i]),
         .gain_out   (gl[i+1]),
         .scale_in   ('0),
         .scale_out  (unused_s),
         .num_x      ('0),
         .num_y      ('0)
      );
      always_ff @(posedge clock) begin
         if (advance) tlen_ff[i+1] <= tlen_ff[i];
      end
   end

   // Scale setup: clamp the gain and form the two products.
   gain_lane_type gend;
   logic [GAIN_BITS-1:0] f_w;
   logic [MAG_BITS-1:0]  gx, gy;
   assign gend = gl[PROD_BITS];
   always_comb begin
      if (gend.sat || (gend.g.quo > PROD_BITS'(GAIN_MAX))) f_w = GAIN_MAX;
      else f_w = gend.g.quo[GAIN_BITS-1:0];
      gx = gend.ax[AXIS_BITS-1] ? MAG_BITS'(-gend.ax) : MAG_BITS'(gend.ax);
      gy = gend.ay[AXIS_BITS-1] ? MAG_BITS'(-gend.ay) : MAG_BITS'(gend.ay);
      num_x_c = gx * f_w;
      num_y_c = gy * f_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_head.valid <= 1'b0;
      end else if (advance) begin
         scale_head.valid <= gend.valid;
         scale_head.dead  <= gend.dead;
         scale_head.zero  <= gend.zero;
         scale_head.neg_x <= gend.ax[AXIS_BITS-1];
         scale_head.neg_y <= gend.ay[AXIS_BITS-1];
         scale_head.len   <= tlen_ff[PROD_BITS];
         scale_head.dx    <= '0;
         scale_head.dy    <= '0;
         num_x_ff[0]      <= num_x_c;
         num_y_ff[0]      <= num_y_c;
      end
   end

   assign sl[0] = scale_head;
   for (genvar i = 0; i < PROD_BITS; i++) begin : g_scale
      gain_lane_type unused_g;
      srdz_div_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .gain_stage (1'b0),
         .step       ($clog2(PROD_BITS)'(i)),
         .gain_in    ('0),
         .gain_out   (unused_g),
         .scale_in   (sl[i]),
         .scale_out  (sl[i+1]),
         .num_x      (num_x_ff[i]),
         .num_y      (num_y_ff[i])
      );
      always_ff @(posedge clock) begin
         if (advance) begin
            num_x_ff[i+1] <= num_x_ff[i];
            num_y_ff[i+1] <= num_y_ff[i];
         end
      end
   end

   // Output register: sign restore, dead zone and zero length forcing.
   scale_lane_type send;
   logic [AXIS_BITS-1:0] qx, qy;
   assign send = sl[PROD_BITS];
   assign qx = AXIS_BITS'(send.dx.quo);
   assign qy = AXIS_BITS'(send.dy.quo);
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= send.valid;
         dead_out_ff  <= send.dead;
         if (send.dead || send.zero) begin
            out_x_ff <= '0;
            out_y_ff <= '0;
         end else begin
            out_x_ff <= send.neg_x ? -qx : qx;
            out_y_ff <= send.neg_y ? -qy : qy;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_x        = out_x_ff;
   assign rsp_out_y        = out_y_ff;
   assign rsp_in_dead_zone = dead_out_ff;

`ifndef SYNTH
   // A result held for a stalled receiver stays valid and keeps its two axis outputs.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_x) && $stable(rsp_out_y))
      else $error("result changed while stalled");
   // A dead zone result always carries zero outputs.
   a_dead: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_in_dead_zone |-> rsp_out_x == '0 && rsp_out_y == '0)
      else $error("dead zone result not zero");
   // The input side stalls exactly when a result waits.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("ready out of step with output register");
`endif

endmodule

### src/srdz_sqrt_cell.sv
// One cell of the square root chain: settles one result bit per cycle while the row advances.
module srdz_sqrt_cell
   import srdz_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic [$clog2(LEN_BITS)-1:0] step,
   input  sqrt_lane_type lane_in,
   output sqrt_lane_type lane_out
);

   sqrt_lane_type lane_ff, lane_in_c;
   logic [SQ_PAD+1:0] rem_sh;
   logic [SQ_PAD+1:0] root_sh;

   // Bit-pair digit recurrence: the remainder stays in place, the trial value shifts.
   always_comb begin
      lane_in_c = lane_in;
      rem_sh    = {2'b00, lane_in.rem} >> (2 * (LEN_BITS - 1 - int'(step)));
      root_sh   = {{(SQ_PAD + 2 - LEN_BITS - 2){1'b0}}, lane_in.root, 2'b01};
      if (rem_sh >= root_sh) begin
         lane_in_c.root = {lane_in.root[LEN_BITS-2:0], 1'b1};
         lane_in_c.rem  = lane_in.rem -
            SQ_PAD'(root_sh << (2 * (LEN_BITS - 1 - int'(step))));
      end else begin
         lane_in_c.root = {lane_in.root[LEN_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lane_ff.valid <= 1'b0;
      end else if (advance) begin
         lane_ff <= lane_in_c;
      end
   end

   assign lane_out = lane_ff;

endmodule

### src/srdz_div_cell.sv
// One cell of the divider chain: one quotient bit per lane per cycle while the row advances.
module srdz_div_cell
   import srdz_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  logic           gain_stage,
   input  logic [$clog2(PROD_BITS)-1:0] step,
   input  gain_lane_type  gain_in,
   output gain_lane_type  gain_out,
   input  scale_lane_type scale_in,
   output scale_lane_type scale_out,
   input  logic [PROD_BITS-1:0] num_x,
   input  logic [PROD_BITS-1:0] num_y
);

   gain_lane_type  gain_ff, gain_c;
   scale_lane_type scale_ff, scale_c;
   logic [GNUM_BITS-1:0] gnum;
   logic [PROD_BITS-1:0] gbit_vec;

   // Each cell takes the dividend bit at its own position, most significant first.
   always_comb begin
      gain_c  = gain_in;
      scale_c = scale_in;
      gnum    = {GNUM_BITS{1'b0}};
      gbit_vec = {PROD_BITS{1'b0}};
      if (gain_stage) begin
         gnum = {gain_in.len, {FRAC_BITS{1'b0}}};
         gbit_vec = PROD_BITS'(gnum);
         gain_c.g = div_step(gain_in.g, gbit_vec[PROD_BITS - 1 - int'(step)],
                             gain_in.span);
      end else begin
         scale_c.dx = div_step(scale_in.dx, num_x[PROD_BITS - 1 - int'(step)],
                               {1'b0, scale_in.len});
         scale_c.dy = div_step(scale_in.dy, num_y[PROD_BITS - 1 - int'(step)],
                               {1'b0, scale_in.len});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff.valid  <= 1'b0;
         scale_ff.valid <= 1'b0;
      end else if (advance) begin
         gain_ff  <= gain_c;
         scale_ff <= scale_c;
      end
   end

   assign gain_out  = gain_ff;
   assign scale_out = scale_ff;

endmodule
